// ----- hdl/fovt_pkg.sv -----
// package: shared types and codes for the frequency ordered visit table
package fovt_pkg;

  localparam logic [1:0] FUNC_TOUCH  = 2'd0;
  localparam logic [1:0] FUNC_LIST   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_LISTED   = 3'd4;

  localparam int          MAX_RESULTS = 16;
  localparam logic [15:0] HITS_MAX    = 16'hFFFF;
  localparam logic [4:0]  AGE_MAX     = 5'd31;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [4:0]  top_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_key;
    logic [15:0] hits;
    logic [4:0]  entry_age;
    logic [3:0]  rank;
    logic        valid_res;
    logic        last;
  } out_item_t;

endpackage

// ----- hdl/fovt_in_if.sv -----
// interface: input channel carrying one operation per transaction
interface fovt_in_if;
  import fovt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fovt_out_if.sv -----
// interface: result channel carrying one result per transaction
interface fovt_out_if;
  import fovt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fovt_front.sv -----
// module: front end, accepts operations, masks keys, drops unused codes, two entry queue
module fovt_front #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  fovt_in_if.sink             in_ch,
  output fovt_pkg::in_item_t  q_data,
  output logic                q_valid,
  input  logic                q_pop
);
  import fovt_pkg::*;

  localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  in_item_t    slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        do_pop;
  in_item_t    cooked;

  // key masking to the stored key width
  always_comb begin
    cooked = in_ch.data;
    cooked.key = '0;
    cooked.key[KW-1:0] = in_ch.data.key[KW-1:0];
  end

  assign in_ch.ready = (fill != 2'd2);
  // unused function code is accepted and dropped here
  assign push    = in_ch.valid && in_ch.ready && (in_ch.data.func != FUNC_UNUSED);
  assign do_pop  = q_pop && (fill != 2'd0);
  assign q_valid = (fill != 2'd0);
  assign q_data  = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cooked;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, do_pop};
    end
  end
endmodule

// ----- hdl/fovt_back.sv -----
// module: back end, table storage, search, bubble move, listing and result register
module fovt_back #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  fovt_pkg::in_item_t  q_data,
  input  logic                q_valid,
  output logic                q_pop,
  fovt_out_if.source          out_ch
);
  import fovt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_BUMP   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_LIST   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [KW-1:0] keys [CAPACITY];
  logic [15:0]   hcnt [CAPACITY];
  logic [4:0]    ages [CAPACITY];
  logic [OW-1:0] occ;

  logic [2:0]    state;
  in_item_t      cur;
  logic [IW-1:0] pos;
  logic [OW-1:0] list_n;
  logic [OW-1:0] list_i;
  logic [2:0]    touch_st;
  logic          out_full;
  out_item_t     out_reg;

  logic [CAPACITY-1:0] match;
  logic                found;
  logic [IW-1:0]       found_idx;
  logic [IW-1:0]       prv;
  logic                swap_ok;
  logic [OW-1:0]       want;
  logic                slot_free;
  logic                list_end;
  out_item_t           res;

  assign slot_free    = !out_full || out_ch.ready;
  assign out_ch.valid = out_full;
  assign out_ch.data  = out_reg;
  assign q_pop        = (state == S_IDLE) && q_valid;

  // parallel key compare over occupied entries
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (OW'(i) < occ) && (keys[i] == cur.key[KW-1:0]);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // one bubble step toward the front
  assign prv = pos - IW'(1);
  assign swap_ok = (pos != '0) &&
                   ((hcnt[pos] > hcnt[prv]) ||
                    ((hcnt[pos] == hcnt[prv]) && (ages[pos] < ages[prv])));

  assign want = (int'(cur.top_count) < int'(occ)) ? OW'(cur.top_count) : occ;

  // final listed entry, by count or by the result limit
  assign list_end = (int'(list_i) + 1 >= int'(list_n)) ||
                    (int'(list_i) + 1 >= MAX_RESULTS);

  // result transaction for the current operation
  always_comb begin
    res      = '0;
    res.last = 1'b1;
    unique case (cur.func)
      FUNC_TOUCH: begin
        res.status    = touch_st;
        res.entry_key = cur.key;
        if (touch_st != ST_FULL) begin
          res.hits      = hcnt[pos];
          res.entry_age = ages[pos];
          res.rank      = 4'(pos);
          res.valid_res = 1'b1;
        end
      end
      FUNC_LIST: begin
        res.status = ST_LISTED;
        if (list_n != '0) begin
          res.entry_key = 32'(keys[list_i[IW-1:0]]);
          res.hits      = hcnt[list_i[IW-1:0]];
          res.entry_age = ages[list_i[IW-1:0]];
          res.rank      = 4'(list_i);
          res.valid_res = 1'b1;
          res.last      = list_end;
        end
      end
      default: begin
        res.status = ST_CLEARED;
      end
    endcase
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      out_full <= 1'b0;
    end else begin
      out_full <= ((state == S_EMIT) && slot_free) || (out_full && !out_ch.ready);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            unique case (q_data.func)
              FUNC_TOUCH: state <= S_SEARCH;
              FUNC_LIST:  state <= S_LIST;
              default:    state <= S_EMIT;
            endcase
          end
        end
        S_SEARCH: begin
          if (found) begin
            pos      <= found_idx;
            touch_st <= ST_HIT;
            state    <= S_BUMP;
          end else if (occ >= OW'(CAPACITY)) begin
            touch_st <= ST_FULL;
            state    <= S_EMIT;
          end else begin
            keys[occ[IW-1:0]] <= cur.key[KW-1:0];
            hcnt[occ[IW-1:0]] <= 16'd1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (OW'(i) < occ && ages[i] != AGE_MAX) begin
                ages[i] <= ages[i] + 5'd1;
              end
            end
            ages[occ[IW-1:0]] <= 5'd2;
            pos      <= occ[IW-1:0];
            occ      <= occ + OW'(1);
            touch_st <= ST_INSERTED;
            state    <= S_EMIT;
          end
        end
        S_BUMP: begin
          if (hcnt[pos] != HITS_MAX) begin
            hcnt[pos] <= hcnt[pos] + 16'd1;
          end
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (swap_ok) begin
            keys[pos] <= keys[prv];
            hcnt[pos] <= hcnt[prv];
            ages[pos] <= ages[prv];
            keys[prv] <= keys[pos];
            hcnt[prv] <= hcnt[pos];
            ages[prv] <= ages[pos];
            pos       <= prv;
          end else begin
            state <= S_EMIT;
          end
        end
        S_LIST: begin
          list_n <= want;
          list_i <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_reg <= res;
            if (res.last) begin
              state <= S_IDLE;
            end
            if (cur.func == FUNC_LIST && !res.last) begin
              list_i <= list_i + OW'(1);
            end
            if (cur.func == FUNC_CLEAR) begin
              occ <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- hdl/frequency_ordered_visit_table.sv -----
// top level: frequency ordered visit table with front queue and back engine
//   channel   dir   payload
//   in_ch     sink  func, key, top_count
//   out_ch    src   status, entry_key, hits, entry_age, rank, valid_res, last
// touch: search, then emit on insert or full drop; a hit bumps and moves first
// list: one table read per cycle while the result register is free
// clear: empties the table; reset (synchronous) empties the table at once
// each result waits in the output register while out_ch is not ready
// the two entry queue keeps taking operations until full while a result waits
module frequency_ordered_visit_table #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  fovt_in_if.sink    in_ch,
  fovt_out_if.source out_ch
);
  import fovt_pkg::*;

  in_item_t q_data;
  logic     q_valid;
  logic     q_pop;

  fovt_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  fovt_back #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

// ----- verif/tb_frequency_ordered_visit_table.sv -----
// testbench: frequency ordered visit table checked against a behavioral table model
module tb_frequency_ordered_visit_table;
  import fovt_pkg::*;

  localparam int CAP = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;

  fovt_in_if  in_ch ();
  fovt_out_if out_ch ();

  frequency_ordered_visit_table #(.CAPACITY(CAP), .KEY_WIDTH(32)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model state
  logic [31:0] tbl_key [CAP];
  logic [15:0] tbl_hits [CAP];
  logic [4:0]  tbl_age [CAP];
  int          tbl_used = 0;
  out_item_t   pending_results[$];

  // sink side controls
  bit sink_idle_on = 1'b1;
  int sink_hold_cycles = 0;
  logic [31:0] keys_seen[$];

  function automatic out_item_t mk_res(logic [2:0] st, logic [31:0] k, logic [15:0] h,
                                       logic [4:0] a, logic [3:0] r, logic v, logic l);
    out_item_t o;
    o.status = st; o.entry_key = k; o.hits = h; o.entry_age = a;
    o.rank = r; o.valid_res = v; o.last = l;
    return o;
  endfunction

  // append one expected result
  function automatic void queue_result(out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // predict the results of one operation and advance the table model
  task automatic predict_table_op(in_item_t it);
    int i, p, cnt;
    bit found;
    logic [31:0] tk;
    logic [15:0] th;
    logic [4:0]  ta;
    found = 1'b0;
    case (it.func)
      FUNC_TOUCH: begin
        for (i = 0; i < tbl_used; i++) begin
          if (!found && tbl_key[i] == it.key) begin
            found = 1'b1;
            p = i;
          end
        end
        if (found) begin
          i = p;
          if (tbl_hits[i] != HITS_MAX) tbl_hits[i]++;
          while (i > 0) begin
            p = i - 1;
            if (tbl_hits[i] < tbl_hits[p]) break;
            if (tbl_hits[i] == tbl_hits[p] && tbl_age[i] >= tbl_age[p]) break;
            tk = tbl_key[i]; th = tbl_hits[i]; ta = tbl_age[i];
            tbl_key[i] = tbl_key[p]; tbl_hits[i] = tbl_hits[p]; tbl_age[i] = tbl_age[p];
            tbl_key[p] = tk; tbl_hits[p] = th; tbl_age[p] = ta;
            i = p;
          end
          queue_result(mk_res(ST_HIT, it.key, tbl_hits[i], tbl_age[i],
                              4'(i), 1'b1, 1'b1));
        end else if (tbl_used >= CAP) begin
          queue_result(mk_res(ST_FULL, it.key, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          tbl_key[tbl_used] = it.key;
          tbl_hits[tbl_used] = 16'd1;
          tbl_age[tbl_used] = 5'd1;
          for (i = 0; i <= tbl_used; i++)
            if (tbl_age[i] != AGE_MAX) tbl_age[i]++;
          queue_result(mk_res(ST_INSERTED, it.key, 16'd1, tbl_age[tbl_used],
                              4'(tbl_used), 1'b1, 1'b1));
          tbl_used++;
        end
      end
      FUNC_LIST: begin
        cnt = tbl_used;
        if (int'(it.top_count) < cnt) cnt = it.top_count;
        if (cnt > MAX_RESULTS) cnt = MAX_RESULTS;
        if (cnt == 0)
          queue_result(mk_res(ST_LISTED, '0, '0, '0, '0, 1'b0, 1'b1));
        for (i = 0; i < cnt; i++)
          queue_result(mk_res(ST_LISTED, tbl_key[i], tbl_hits[i], tbl_age[i],
                              4'(i), 1'b1, 1'(i == cnt - 1)));
      end
      FUNC_CLEAR: begin
        tbl_used = 0;
        queue_result(mk_res(ST_CLEARED, '0, '0, '0, '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  bit src_idle_on = 1'b1;

  // drive one operation and wait for its transaction
  task automatic send_op(logic [1:0] f, logic [31:0] k, logic [4:0] n);
    in_item_t it;
    it.func = f; it.key = k; it.top_count = n;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_table_op(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_seen.size() != 0 && $urandom_range(0, 3) != 0)
      return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
    return $urandom();
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d key=%h", got.status, got.entry_key);
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); failed = 1'b1;
        end
        if (got.entry_key !== exp_r.entry_key) begin
          $error("entry_key exp %h got %h", exp_r.entry_key, got.entry_key); failed = 1'b1;
        end
        if (got.hits !== exp_r.hits) begin
          $error("hits exp %0d got %0d", exp_r.hits, got.hits); failed = 1'b1;
        end
        if (got.entry_age !== exp_r.entry_age) begin
          $error("entry_age exp %0d got %0d", exp_r.entry_age, got.entry_age); failed = 1'b1;
        end
        if (got.rank !== exp_r.rank) begin
          $error("rank exp %0d got %0d", exp_r.rank, got.rank); failed = 1'b1;
        end
        if (got.valid_res !== exp_r.valid_res) begin
          $error("valid_res exp %0d got %0d", exp_r.valid_res, got.valid_res); failed = 1'b1;
        end
        if (got.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, got.last); failed = 1'b1;
        end
      end
    end
  end

  // receiver stalls: random bursts, or a long counted hold-off
  int sink_burst = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      sink_hold_cycles <= sink_hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
      sink_burst <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // directed: extremes of keys, hit and insert, list bounds, unused func
  task automatic test_directed();
    send_op(FUNC_LIST, 32'h0, 5'd3);
    send_op(FUNC_TOUCH, 32'h0, 5'd0);
    send_op(FUNC_TOUCH, 32'hFFFF_FFFF, 5'd31);
    send_op(FUNC_TOUCH, 32'hFFFF_FFFF, 5'd0);
    send_op(FUNC_TOUCH, 32'hA5A5_5A5A, 5'd0);
    send_op(FUNC_TOUCH, 32'hA5A5_5A5A, 5'd0);
    send_op(FUNC_TOUCH, 32'hA5A5_5A5A, 5'd0);
    send_op(FUNC_UNUSED, 32'h1234_5678, 5'd5);
    send_op(FUNC_LIST, 32'h0, 5'd0);
    send_op(FUNC_LIST, 32'h0, 5'd2);
    send_op(FUNC_LIST, 32'h0, 5'd31);
    send_op(FUNC_CLEAR, 32'h0, 5'd0);
    send_op(FUNC_LIST, 32'h0, 5'd16);
    wait_drained();
  endtask

  // fill the table, hit its last key, then miss on a full table and list it all
  task automatic test_full_table();
    int i;
    for (i = 0; i < CAP; i++) send_op(FUNC_TOUCH, 32'h100 + i, 5'd0);
    send_op(FUNC_TOUCH, 32'h100 + CAP - 1, 5'd0);
    send_op(FUNC_TOUCH, 32'hDEAD_BEEF, 5'd0);
    send_op(FUNC_LIST, 32'h0, 5'd16);
    send_op(FUNC_LIST, 32'h0, 5'd17);
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering list operations
  task automatic test_backpressure();
    sink_hold_cycles = 300;
    repeat (6) send_op(FUNC_LIST, 32'h0, 5'd16);
    wait_drained();
  endtask

  // random touch-heavy traffic on a small key pool, with lists and clears
  task automatic test_random(int n, bit idle);
    int i, r;
    src_idle_on = idle;
    sink_idle_on = idle;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if (keys_seen.size() < 20 && $urandom_range(0, 2) == 0)
          keys_seen.insert(keys_seen.size(), $urandom());
        send_op(FUNC_TOUCH, pick_key(), 5'($urandom()));
      end else if (r < 90) begin
        send_op(FUNC_LIST, $urandom(), 5'($urandom()));
      end else if (r < 95) begin
        send_op(FUNC_CLEAR, $urandom(), 5'($urandom()));
      end else begin
        send_op(FUNC_UNUSED, $urandom(), 5'($urandom()));
      end
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(150, 1'b1);
    test_random(50, 1'b0);
    if (!failed && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- frequency_ordered_visit_table.f -----
hdl/fovt_pkg.sv
hdl/fovt_in_if.sv
hdl/fovt_out_if.sv
hdl/fovt_front.sv
hdl/fovt_back.sv
hdl/frequency_ordered_visit_table.sv
verif/tb_frequency_ordered_visit_table.sv
